@@ sv/cmfs_pkg.sv @@
// Shared types and constants for the cube map face selector.
package cmfs_pkg;

  // Quotient bits per coordinate; one division cell per bit.
  localparam int QBITS = 16;

  typedef enum logic [2:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_t;

  // Payload handed from cell to cell along the divider chain.
  typedef struct packed {
    logic [15:0] rem_u;   // partial remainder, u lane
    logic [15:0] rem_v;   // partial remainder, v lane
    logic [15:0] q_u;     // quotient bits gathered so far, u lane
    logic [15:0] q_v;     // quotient bits gathered so far, v lane
    logic [15:0] m;       // magnitude of the major axis (divisor)
    face_t       face;
    logic        zero;    // zero direction vector
    logic        full_u;  // u numerator equals +m, saturate
    logic        full_v;  // v numerator equals +m, saturate
  } lane_t;

endpackage

@@ sv/cmfs_in_if.sv @@
// Request channel carrying one direction vector.
interface cmfs_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

@@ sv/cmfs_out_if.sv @@
// Result channel carrying face and face coordinates.
interface cmfs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  face;
  logic [15:0] coord_u;
  logic [15:0] coord_v;
  logic        valid_res;

  modport source (output valid, output face, output coord_u, output coord_v,
                  output valid_res, input ready);
  modport sink   (input valid, input face, input coord_u, input coord_v,
                  input valid_res, output ready);
endinterface

@@ sv/cmfs_select.sv @@
// Front stage: major axis pick, face numerators and divider operands.
module cmfs_select (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  input  logic signed [15:0]  dir_x,
  input  logic signed [15:0]  dir_y,
  input  logic signed [15:0]  dir_z,
  output logic                up_ready,
  input  logic                dn_ready,
  output logic                valid_r,
  output cmfs_pkg::lane_t     lane_r
);

  logic [15:0] ux, uy, uz;
  logic [15:0] ax, ay, az;
  logic signed [16:0] xs, ys, zs;
  logic xmax, ymax, zmax;
  logic xpos, ypos, zpos;
  logic [15:0] m;
  logic signed [16:0] uc, vc;
  logic [17:0] off_u, off_v, two_m;
  cmfs_pkg::face_t face;
  cmfs_pkg::lane_t lane_nxt;
  logic valid_nxt;

  assign ux = dir_x;
  assign uy = dir_y;
  assign uz = dir_z;
  assign ax = ux[15] ? (~ux + 16'd1) : ux;
  assign ay = uy[15] ? (~uy + 16'd1) : uy;
  assign az = uz[15] ? (~uz + 16'd1) : uz;
  assign xs = {dir_x[15], dir_x};
  assign ys = {dir_y[15], dir_y};
  assign zs = {dir_z[15], dir_z};

  assign xmax = (ax >= ay) && (ax >= az);
  assign ymax = (ay >= ax) && (ay >= az);
  assign zmax = (az >= ax) && (az >= ay);
  // Zero counts as negative.
  assign xpos = !dir_x[15] && (dir_x != 16'sd0);
  assign ypos = !dir_y[15] && (dir_y != 16'sd0);
  assign zpos = !dir_z[15] && (dir_z != 16'sd0);

  // Later tests override earlier ones, so ties go to the later face.
  always_comb begin
    face = cmfs_pkg::FACE_PX;
    m    = '0;
    uc   = '0;
    vc   = '0;
    if (xmax && xpos) begin
      face = cmfs_pkg::FACE_PX; m = ax; uc = -zs; vc = ys;
    end
    if (xmax && !xpos) begin
      face = cmfs_pkg::FACE_NX; m = ax; uc = zs;  vc = ys;
    end
    if (ymax && ypos) begin
      face = cmfs_pkg::FACE_PY; m = ay; uc = xs;  vc = -zs;
    end
    if (ymax && !ypos) begin
      face = cmfs_pkg::FACE_NY; m = ay; uc = xs;  vc = zs;
    end
    if (zmax && zpos) begin
      face = cmfs_pkg::FACE_PZ; m = az; uc = xs;  vc = ys;
    end
    if (zmax && !zpos) begin
      face = cmfs_pkg::FACE_NZ; m = az; uc = -xs; vc = ys;
    end
  end

  // Offset numerators lie in [0, 2m]; only 2m itself needs a 17th bit.
  assign off_u = {uc[16], uc} + {2'b00, m};
  assign off_v = {vc[16], vc} + {2'b00, m};
  assign two_m = {1'b0, m, 1'b0};

  always_comb begin
    lane_nxt        = '0;
    lane_nxt.rem_u  = off_u[15:0];
    lane_nxt.rem_v  = off_v[15:0];
    lane_nxt.m      = m;
    lane_nxt.face   = face;
    lane_nxt.zero   = (m == 16'd0);
    lane_nxt.full_u = (off_u == two_m);
    lane_nxt.full_v = (off_v == two_m);
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

@@ sv/cmfs_div_cell.sv @@
// One restoring division step for both coordinate lanes.
module cmfs_div_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  input  cmfs_pkg::lane_t  up_lane,
  output logic             up_ready,
  input  logic             dn_ready,
  output logic             valid_r,
  output cmfs_pkg::lane_t  lane_r
);

  logic            ge_u, ge_v;
  logic [15:0]     red_u, red_v;
  cmfs_pkg::lane_t lane_nxt;

  assign ge_u  = up_lane.rem_u >= up_lane.m;
  assign ge_v  = up_lane.rem_v >= up_lane.m;
  assign red_u = ge_u ? (up_lane.rem_u - up_lane.m) : up_lane.rem_u;
  assign red_v = ge_v ? (up_lane.rem_v - up_lane.m) : up_lane.rem_v;

  // Reduced remainder is below m, so doubling it stays in 16 bits.
  always_comb begin
    lane_nxt       = up_lane;
    lane_nxt.rem_u = {red_u[14:0], 1'b0};
    lane_nxt.rem_v = {red_v[14:0], 1'b0};
    lane_nxt.q_u   = {up_lane.q_u[14:0], ge_u};
    lane_nxt.q_v   = {up_lane.q_v[14:0], ge_v};
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

@@ sv/cube_map_face_select.sv @@
// Top level: cube map face selector with a chain of division cells.
//
//   channel  role   handshake       payload
//   in_if    sink   valid / ready   dir_x, dir_y, dir_z (signed 16)
//   out_if   source valid / ready   face (3), coord_u (16), coord_v (16), valid_res
//
// One request enters per cycle while in_if.ready is high. There is one front
// stage for the axis pick, then 16 division cells, one per quotient bit.
// Each cell retires one quotient bit for both coordinates and hands the
// request on every cycle that its successor is ready to take it.
// Reset (rst_n low at a clock edge) empties every stage.
// Each stage advances when it is empty or its successor advances, so bubbles
// collapse; requests keep entering while a result waits, until stages fill.
module cube_map_face_select (
  input  logic       clk,
  input  logic       rst_n,
  cmfs_in_if.sink    in_if,
  cmfs_out_if.source out_if
);

  localparam int NSTG = cmfs_pkg::QBITS + 1;

  // Stage 0 is the front stage; stages 1..QBITS are division cells.
  logic            stg_valid [NSTG];
  cmfs_pkg::lane_t stg_lane  [NSTG];
  logic            stg_ready [NSTG+1];
  cmfs_pkg::lane_t last;

  assign stg_ready[NSTG] = out_if.ready;
  assign in_if.ready     = stg_ready[0];

  cmfs_select u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_if.valid),
    .dir_x    (in_if.dir_x),
    .dir_y    (in_if.dir_y),
    .dir_z    (in_if.dir_z),
    .up_ready (stg_ready[0]),
    .dn_ready (stg_ready[1]),
    .valid_r  (stg_valid[0]),
    .lane_r   (stg_lane[0])
  );

  // Quotient bits come out MSB first, one per cell.
  for (genvar k = 1; k < NSTG; k++) begin : g_cell
    cmfs_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[k-1]),
      .up_lane  (stg_lane[k-1]),
      .up_ready (stg_ready[k]),
      .dn_ready (stg_ready[k+1]),
      .valid_r  (stg_valid[k]),
      .lane_r   (stg_lane[k])
    );
  end

  assign last = stg_lane[NSTG-1];

  // Drop the quotient for a zero vector; saturate a numerator of +m.
  assign out_if.valid     = stg_valid[NSTG-1];
  assign out_if.face      = last.face;
  assign out_if.valid_res = !last.zero;
  assign out_if.coord_u   = last.zero ? 16'd0 : (last.full_u ? 16'hFFFF : last.q_u);
  assign out_if.coord_v   = last.zero ? 16'd0 : (last.full_v ? 16'hFFFF : last.q_v);

`ifndef ASSERT_OFF
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.valid_res) |->
      (out_if.face == cmfs_pkg::FACE_NZ && out_if.coord_u == 16'd0 &&
       out_if.coord_v == 16'd0))
    else $error("zero vector result malformed");

  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.ready |-> in_if.ready)
    else $error("input stalled while output drains");

  a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !stg_valid[1] |-> in_if.ready)
    else $error("input stalled behind an empty cell");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> stg_valid[0])
    else $error("accepted request not captured");
`endif

endmodule

@@ tb/sv/cube_map_face_select_tb.sv @@
// Self-checking testbench for the cube map face selector: directed and random directions.
module cube_map_face_select_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 10;
  localparam int RESET_TICKS = 6;
  localparam int RAND_ITEMS  = 930;
  localparam int IDLE_PCT    = 14;
  localparam int CALM_FIRST  = 300;   // random requests without any idling
  localparam int CALM_LAST   = 499;
  localparam int HOLD_AT     = 650;   // requests sent before the receiver holds off
  localparam int HOLD_CYCLES = 60;    // well beyond the 17-deep pipeline
  localparam int DRAIN_TAIL  = 24;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    cmfs_pkg::face_t face;
    logic [15:0]     coord_u;
    logic [15:0]     coord_v;
    logic            valid_res;
  } face_coords_t;

  // Predict face and coordinates per request and match them against the results.
  class face_scoreboard;
    face_coords_t coords_q[$];
    int           errors;

    function new();
      errors = 0;
    endfunction

    // floor((num + m) * 65536 / (2m)), clamped to the 16-bit range
    static function logic [15:0] coord_frac(int num, int m);
      longint off;
      longint q;
      off = longint'(num) + longint'(m);
      if (off < 0) off = 0;
      q = (off << 16) / (2 * longint'(m));
      return (q > 65535) ? 16'hFFFF : q[15:0];
    endfunction

    static function face_coords_t face_coords(logic signed [15:0] x, logic signed [15:0] y,
                                              logic signed [15:0] z);
      int sx, sy, sz, ax, ay, az, m, uc, vc;
      bit xmax, ymax, zmax;
      face_coords_t r;
      sx = int'(x);
      sy = int'(y);
      sz = int'(z);
      ax = (sx < 0) ? -sx : sx;
      ay = (sy < 0) ? -sy : sy;
      az = (sz < 0) ? -sz : sz;
      xmax = (ax >= ay) && (ax >= az);
      ymax = (ay >= ax) && (ay >= az);
      zmax = (az >= ax) && (az >= ay);
      m = 0;
      uc = 0;
      vc = 0;
      r = '0;
      r.face = cmfs_pkg::FACE_PX;
      // Later tests override earlier ones: ties go to the later face.
      if (xmax && sx > 0) begin
        m = ax; uc = -sz; vc = sy;  r.face = cmfs_pkg::FACE_PX;
      end
      if (xmax && sx <= 0) begin
        m = ax; uc = sz;  vc = sy;  r.face = cmfs_pkg::FACE_NX;
      end
      if (ymax && sy > 0) begin
        m = ay; uc = sx;  vc = -sz; r.face = cmfs_pkg::FACE_PY;
      end
      if (ymax && sy <= 0) begin
        m = ay; uc = sx;  vc = sz;  r.face = cmfs_pkg::FACE_NY;
      end
      if (zmax && sz > 0) begin
        m = az; uc = sx;  vc = sy;  r.face = cmfs_pkg::FACE_PZ;
      end
      if (zmax && sz <= 0) begin
        m = az; uc = -sx; vc = sy;  r.face = cmfs_pkg::FACE_NZ;
      end
      if (m != 0) begin
        r.coord_u   = coord_frac(uc, m);
        r.coord_v   = coord_frac(vc, m);
        r.valid_res = 1'b1;
      end
      return r;
    endfunction

    function void note_direction(logic signed [15:0] x, logic signed [15:0] y,
                                 logic signed [15:0] z);
      coords_q.push_back(face_coords(x, y, z));
    endfunction

    function void check_result(logic [2:0] face, logic [15:0] u, logic [15:0] v,
                               logic vres);
      face_coords_t want;
      if (coords_q.size() == 0) begin
        $display("%0t: unexpected result face=%0d u=%0d v=%0d valid_res=%b",
                 $time, face, u, v, vres);
        errors++;
        return;
      end
      want = coords_q.pop_front();
      if (face !== want.face) begin
        $display("%0t: face expected %0d actual %0d", $time, want.face, face);
        errors++;
      end
      if (u !== want.coord_u) begin
        $display("%0t: coord_u expected %0d actual %0d", $time, want.coord_u, u);
        errors++;
      end
      if (v !== want.coord_v) begin
        $display("%0t: coord_v expected %0d actual %0d", $time, want.coord_v, v);
        errors++;
      end
      if (vres !== want.valid_res) begin
        $display("%0t: valid_res expected %b actual %b", $time, want.valid_res, vres);
        errors++;
      end
    endfunction

    function int pending();
      return coords_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  cmfs_in_if  in_ch();
  cmfs_out_if out_ch();

  cube_map_face_select u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  face_scoreboard sb = new();
  int             idle_pct = IDLE_PCT;
  int             sent_count = 0;
  int             quiet_cycles = 0;
  bit             held_off = 1'b0;

  // Sample both handshakes at the edge, before any driver update lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_direction(in_ch.dir_x, in_ch.dir_y, in_ch.dir_z);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.face, out_ch.coord_u, out_ch.coord_v, out_ch.valid_res);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Present one request; idle at random first, then hold until it is taken.
  task automatic send_direction(logic signed [15:0] x, logic signed [15:0] y,
                                logic signed [15:0] z);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.dir_x <= 16'($urandom);
      in_ch.dir_y <= 16'($urandom);
      in_ch.dir_z <= 16'($urandom);
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.dir_x <= x;
    in_ch.dir_y <= y;
    in_ch.dir_z <= z;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
  endtask

  function automatic logic signed [15:0] edge_component();
    case ($urandom_range(6))
      0:       return -16'sd32768;
      1:       return -16'sd32767;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      5:       return 16'sd32766;
      default: return 16'sd32767;
    endcase
  endfunction

  // Magnitude near a shared base, so axes tie or nearly tie.
  function automatic logic signed [15:0] near_component(int base);
    int c;
    c = base - int'($urandom_range(2));
    return ($urandom_range(1) != 0) ? 16'(c) : 16'(-c);
  endfunction

  // Receiver: random ready, with one long hold-off to back the pipeline up.
  initial begin
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held_off && sent_count >= HOLD_AT) begin
        held_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= idle_pct);
        @(posedge clk);
      end
    end
  end

  initial begin
    int base;
    int mode;
    logic signed [15:0] x, y, z;

    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.dir_x <= '0;
    in_ch.dir_y <= '0;
    in_ch.dir_z <= '0;
    repeat (RESET_TICKS) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero vector: invalid, lands on -Z with zero coordinates.
    send_direction(16'sd0, 16'sd0, 16'sd0);
    // One clear winner per face.
    send_direction(16'sd1000, 16'sd10, -16'sd20);
    send_direction(-16'sd1000, 16'sd300, 16'sd400);
    send_direction(16'sd50, 16'sd1000, -16'sd999);
    send_direction(-16'sd70, -16'sd1000, 16'sd600);
    send_direction(-16'sd5, 16'sd7, 16'sd1000);
    send_direction(16'sd900, -16'sd800, -16'sd1000);
    // Ties: the later face wins.
    send_direction(16'sd5, 16'sd5, 16'sd5);
    send_direction(-16'sd5, -16'sd5, -16'sd5);
    send_direction(16'sd7, 16'sd7, 16'sd0);
    send_direction(16'sd7, -16'sd7, 16'sd3);
    send_direction(16'sd9, 16'sd0, -16'sd9);
    // Zero components off the major axis; a zero major axis means all are zero.
    send_direction(16'sd3, 16'sd0, 16'sd0);
    send_direction(16'sd0, 16'sd0, -16'sd1);
    send_direction(16'sd1, 16'sd0, 16'sd0);
    // Full-scale numerators saturate, the opposite edge gives zero.
    send_direction(16'sd100, 16'sd100, 16'sd20);
    send_direction(16'sd100, -16'sd50, -16'sd100);
    send_direction(-16'sd100, 16'sd0, -16'sd100);
    // Extremes, including a magnitude of 32768.
    send_direction(-16'sd32768, 16'sd32767, -16'sd32768);
    send_direction(16'sd32767, 16'sd32767, 16'sd32767);
    send_direction(-16'sd32768, 16'sd0, 16'sd0);
    send_direction(16'sd32767, -16'sd32768, 16'sd0);
    send_direction(-16'sd32768, -16'sd32768, -16'sd32768);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      idle_pct = (i >= CALM_FIRST && i <= CALM_LAST) ? 0 : IDLE_PCT;
      mode = $urandom_range(9);
      base = $urandom_range(32767, 2);
      if (mode < 4) begin
        x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
      end else if (mode < 6) begin
        x = edge_component(); y = edge_component(); z = edge_component();
      end else if (mode < 8) begin
        x = 16'($urandom_range(16)) - 16'sd8;
        y = 16'($urandom_range(16)) - 16'sd8;
        z = 16'($urandom_range(16)) - 16'sd8;
      end else begin
        x = near_component(base); y = near_component(base); z = near_component(base);
      end
      send_direction(x, y, z);
    end
    idle_pct = IDLE_PCT;
    in_ch.valid <= 1'b0;

    // Drain, then let the pipeline settle; the watchdog bounds the wait.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/cmfs_pkg.sv
sv/cmfs_in_if.sv
sv/cmfs_out_if.sv
sv/cmfs_select.sv
sv/cmfs_div_cell.sv
sv/cube_map_face_select.sv
tb/sv/cube_map_face_select_tb.sv
